/* src/bitmap_page_frame_allocator_core_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("bpfa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("bpfa assertion failed");

`endif

/* src/bpfa_pkg.sv */
`default_nettype none

package bpfa_pkg;

    // Field and word widths.
    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;
    localparam int PAGE_W     = 16;
    localparam int LIM_W      = 17;
    localparam int LWORD_W    = LIM_W - BIT_W;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN     = 1'd1;

    // Reset value of the page count register.
    localparam logic [CFG_DATA_W-1:0] PAGES_RESET = 17'h10000;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_CHK,
        ST_SCAN,
        ST_RUN_SETUP,
        ST_RUN,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

/* src/bpfa_req_if.sv */
`default_nettype none

// Request channel: one item per allocate, release or reserve.
interface bpfa_req_if;
    logic                              valid;
    logic                              ready;
    logic [bpfa_pkg::REQ_W-1:0]        req_type;
    logic [bpfa_pkg::PAGE_W-1:0]       first_page;
    logic [bpfa_pkg::LIM_W-1:0]        page_count;

    modport source (output valid, req_type, first_page, page_count, input ready);
    modport sink (input valid, req_type, first_page, page_count, output ready);
endinterface

`default_nettype wire

/* src/bpfa_rsp_if.sv */
`default_nettype none

// Result channel: one item per request.
interface bpfa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [bpfa_pkg::PAGE_W-1:0]       page_index;
    logic                              status;

    modport source (output valid, page_index, status, input ready);
    modport sink (input valid, page_index, status, output ready);
endinterface

`default_nettype wire

/* src/bpfa_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/bitmap_page_frame_allocator_core.sv */
// An allocate whose hint page is free, and an empty run, give a result without a map walk.
// An allocate with a rescan, and a release or reserve, walk W map words (one word read per
// cycle) first; other requests go straight to the result. One request is handled at a time.
// A result not yet taken stalls the next result, and with it the input.
// Reset (rst_n low, asynchronous) marks all pages used by a clearing pass over all
// MAX_PAGES/64 map words, rounded up (1024 at the default), during which no item is accepted.
`default_nettype none

module bitmap_page_frame_allocator_core #(
    parameter int unsigned MAX_PAGES = 65536
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [bpfa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bpfa_pkg::CFG_DATA_W-1:0]       cfg_data,
    bpfa_req_if.sink                                   req,
    bpfa_rsp_if.source                                 rsp
);

    localparam int MAP_WORDS = (MAX_PAGES + 63) / 64;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WW        = bpfa_pkg::WORD_W;
    localparam int BW        = bpfa_pkg::BIT_W;
    localparam int LW        = bpfa_pkg::LIM_W;
    localparam int LWW       = bpfa_pkg::LWORD_W;
    localparam int PW        = bpfa_pkg::PAGE_W;

    // Index of the lowest set bit.
    function automatic logic [BW-1:0] low_index(input logic [WW-1:0] f);
        logic [WW-1:0] one_hot;
        logic [BW-1:0] idx;
        one_hot = f & (~f + WW'(1));
        idx = '0;
        for (int i = 0; i < WW; i++)
        begin
            if (one_hot[i])
            begin
                idx = idx | BW'(i);
            end
        end
        return idx;
    endfunction

    // Index of the highest set bit.
    function automatic logic [BW-1:0] high_index(input logic [WW-1:0] f);
        logic [WW-1:0] rev;
        for (int i = 0; i < WW; i++)
        begin
            rev[i] = f[WW-1-i];
        end
        return BW'(WW - 1) - low_index(rev);
    endfunction

    // Control state.
    bpfa_pkg::state_t state_reg, state_next;
    logic [LW-1:0]    pages_reg;
    logic             top_down_reg;
    logic [LW-1:0]    hint_reg, hint_next;
    logic [WA_W-1:0]  clr_addr_reg, clr_addr_next;
    logic             walk_done_reg, walk_done_next;
    logic             chk_valid_reg, chk_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state.
    logic [bpfa_pkg::REQ_W-1:0] cur_type_reg, cur_type_next;
    logic [PW-1:0]    cur_first_reg, cur_first_next;
    logic [LW-1:0]    cur_count_reg, cur_count_next;
    logic [WA_W-1:0]  walk_addr_reg, walk_addr_next;
    logic [WA_W-1:0]  walk_end_reg, walk_end_next;
    logic             walk_down_reg, walk_down_next;
    logic [WA_W-1:0]  chk_addr_reg, chk_addr_next;
    logic             chk_last_reg, chk_last_next;
    logic [LW-1:0]    run_endm1_reg, run_endm1_next;
    logic [PW-1:0]    res_page_reg, res_page_next;
    logic             res_status_reg, res_status_next;
    logic [PW-1:0]    out_page_reg, out_page_next;
    logic             out_status_reg, out_status_next;

    // Map memory ports.
    logic             wr_en;
    logic [WA_W-1:0]  wr_addr;
    logic [WW-1:0]    wr_data;
    logic             rd_en;
    logic [WA_W-1:0]  rd_addr;
    logic [WW-1:0]    rd_data;

    // Shared decode.
    logic             accept;
    logic             out_free;
    logic [LW-1:0]    lim;
    logic [LW-1:0]    lim_m1;
    logic             hint_hit;
    logic [LWW-1:0]   chk_w;
    logic [WW-1:0]    scan_mask;
    logic [WW-1:0]    free_w;
    logic [BW-1:0]    found_bit;
    logic [LW-1:0]    found_page;
    logic             scan_hit;
    logic             scan_fail;
    logic [LW:0]      run_sum;
    logic [LW-1:0]    run_end;
    logic [LW-1:0]    run_end_m1;
    logic             run_empty;
    logic [BW-1:0]    run_lo;
    logic [BW-1:0]    run_hi;
    logic [WW-1:0]    run_mask;
    logic [WW-1:0]    run_wdata;
    logic             walk_rd;
    logic             walk_at_end;

    bpfa_ram #(
        .WIDTH (WW),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake.
    assign req.ready  = (state_reg == bpfa_pkg::ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.page_index = out_page_reg;
    assign rsp.status     = out_status_reg;

    // Effective page limit, clipped to the map size.
    assign lim    = (32'(pages_reg) > MAX_PAGES) ? LW'(MAX_PAGES) : pages_reg;
    assign lim_m1 = lim - LW'(1);

    // Hint page check on the word read at acceptance.
    assign hint_hit = (hint_reg < lim) && !rd_data[hint_reg[BW-1:0]];

    // Scan check on the word returned by the walker.
    assign chk_w = LWW'(chk_addr_reg);
    always_comb
    begin
        if (chk_w < lim[LW-1:BW])
        begin
            scan_mask = {WW{1'b1}};
        end
        else if (chk_w == lim[LW-1:BW])
        begin
            scan_mask = ~({WW{1'b1}} << lim[BW-1:0]);
        end
        else
        begin
            scan_mask = '0;
        end
    end
    assign free_w     = ~rd_data & scan_mask;
    assign found_bit  = top_down_reg ? high_index(free_w) : low_index(free_w);
    assign found_page = {chk_w, found_bit};
    assign scan_hit   = chk_valid_reg && (free_w != '0);
    assign scan_fail  = chk_valid_reg && (free_w == '0) && chk_last_reg;

    // Run bounds, clipped to the page limit. The sum keeps its carry so that
    // a long run starting high is clipped rather than wrapped.
    assign run_sum    = {2'b00, cur_first_reg} + {1'b0, cur_count_reg};
    assign run_end    = (run_sum > {1'b0, lim}) ? lim : run_sum[LW-1:0];
    assign run_end_m1 = run_end - LW'(1);
    assign run_empty  = ({1'b0, cur_first_reg} >= run_end);

    // Bits of the current word covered by the run.
    assign run_lo    = (chk_w == {1'b0, cur_first_reg[PW-1:BW]}) ? cur_first_reg[BW-1:0] : '0;
    assign run_hi    = (chk_w == run_endm1_reg[LW-1:BW]) ? run_endm1_reg[BW-1:0] : BW'(WW - 1);
    assign run_mask  = ({WW{1'b1}} << run_lo) & ({WW{1'b1}} >> (BW'(WW - 1) - run_hi));
    assign run_wdata = (cur_type_reg == bpfa_pkg::REQ_RESERVE) ? (rd_data | run_mask)
                                                              : (rd_data & ~run_mask);

    // Word walker issues one read per cycle.
    assign walk_rd     = ((state_reg == bpfa_pkg::ST_SCAN) || (state_reg == bpfa_pkg::ST_RUN))
                         && !walk_done_reg;
    assign walk_at_end = (walk_addr_reg == walk_end_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpfa_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == WA_W'(MAP_WORDS - 1))
                begin
                    state_next = bpfa_pkg::ST_IDLE;
                end
            end
            bpfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        bpfa_pkg::REQ_ALLOC:   state_next = bpfa_pkg::ST_ALLOC_CHK;
                        bpfa_pkg::REQ_RELEASE,
                        bpfa_pkg::REQ_RESERVE: state_next = bpfa_pkg::ST_RUN_SETUP;
                        default:               state_next = bpfa_pkg::ST_RESP;
                    endcase
                end
            end
            bpfa_pkg::ST_ALLOC_CHK:
            begin
                if (hint_hit || (lim == '0))
                begin
                    state_next = bpfa_pkg::ST_RESP;
                end
                else
                begin
                    state_next = bpfa_pkg::ST_SCAN;
                end
            end
            bpfa_pkg::ST_SCAN:
            begin
                if (scan_hit || scan_fail)
                begin
                    state_next = bpfa_pkg::ST_RESP;
                end
            end
            bpfa_pkg::ST_RUN_SETUP:
            begin
                state_next = run_empty ? bpfa_pkg::ST_RESP : bpfa_pkg::ST_RUN;
            end
            bpfa_pkg::ST_RUN:
            begin
                if (chk_valid_reg && chk_last_reg)
                begin
                    state_next = bpfa_pkg::ST_RESP;
                end
            end
            bpfa_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = bpfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and result.
    always_comb
    begin
        hint_next       = hint_reg;
        clr_addr_next   = clr_addr_reg;
        cur_type_next   = cur_type_reg;
        cur_first_next  = cur_first_reg;
        cur_count_next  = cur_count_reg;
        walk_addr_next  = walk_addr_reg;
        walk_end_next   = walk_end_reg;
        walk_down_next  = walk_down_reg;
        walk_done_next  = walk_done_reg;
        run_endm1_next  = run_endm1_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = chk_addr_reg;
        wr_data         = rd_data;
        rd_en           = walk_rd;
        rd_addr         = walk_addr_reg;

        // The walker tags each read with its address and end mark.
        chk_valid_next  = walk_rd;
        chk_addr_next   = walk_addr_reg;
        chk_last_next   = walk_at_end;
        if (walk_rd)
        begin
            walk_addr_next = walk_down_reg ? (walk_addr_reg - WA_W'(1))
                                           : (walk_addr_reg + WA_W'(1));
            walk_done_next = walk_at_end;
        end

        // Output register drains on the consumer's ready.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bpfa_pkg::ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = {WW{1'b1}};
                clr_addr_next = clr_addr_reg + WA_W'(1);
            end
            bpfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cur_type_next   = req.req_type;
                    cur_first_next  = req.first_page;
                    cur_count_next  = req.page_count;
                    res_page_next   = '0;
                    res_status_next = 1'b0;
                    rd_en           = 1'b1;
                    rd_addr         = WA_W'(hint_reg[LW-1:BW]);
                end
            end
            bpfa_pkg::ST_ALLOC_CHK:
            begin
                if (hint_hit)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = WA_W'(hint_reg[LW-1:BW]);
                    wr_data       = rd_data | (WW'(1) << hint_reg[BW-1:0]);
                    res_page_next = hint_reg[PW-1:0];
                    hint_next     = top_down_reg ? (hint_reg - LW'(1)) : (hint_reg + LW'(1));
                end
                else if (lim != '0)
                begin
                    walk_addr_next = top_down_reg ? WA_W'(lim_m1[LW-1:BW]) : '0;
                    walk_end_next  = top_down_reg ? '0 : WA_W'(lim_m1[LW-1:BW]);
                    walk_down_next = top_down_reg;
                    walk_done_next = 1'b0;
                end
                else
                begin
                    res_status_next = 1'b1;
                end
            end
            bpfa_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = chk_addr_reg;
                    wr_data       = rd_data | (WW'(1) << found_bit);
                    res_page_next = found_page[PW-1:0];
                    hint_next     = top_down_reg ? (found_page - LW'(1))
                                                 : (found_page + LW'(1));
                end
                else if (scan_fail)
                begin
                    res_status_next = 1'b1;
                end
            end
            bpfa_pkg::ST_RUN_SETUP:
            begin
                if (!run_empty)
                begin
                    walk_addr_next = WA_W'(cur_first_reg[PW-1:BW]);
                    walk_end_next  = WA_W'(run_end_m1[LW-1:BW]);
                    walk_down_next = 1'b0;
                    walk_done_next = 1'b0;
                    run_endm1_next = run_end_m1;
                end
            end
            bpfa_pkg::ST_RUN:
            begin
                if (chk_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = chk_addr_reg;
                    wr_data = run_wdata;
                end
            end
            bpfa_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_page_next   = res_page_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg    <= bpfa_pkg::PAGES_RESET;
            top_down_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bpfa_pkg::REG_PAGES_IN_USE: pages_reg    <= cfg_data;
                bpfa_pkg::REG_TOP_DOWN:     top_down_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpfa_pkg::ST_CLEAR;
            hint_reg      <= '0;
            clr_addr_reg  <= '0;
            walk_done_reg <= 1'b1;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            clr_addr_reg  <= clr_addr_next;
            walk_done_reg <= walk_done_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_type_reg   <= cur_type_next;
        cur_first_reg  <= cur_first_next;
        cur_count_reg  <= cur_count_next;
        walk_addr_reg  <= walk_addr_next;
        walk_end_reg   <= walk_end_next;
        walk_down_reg  <= walk_down_next;
        chk_addr_reg   <= chk_addr_next;
        chk_last_reg   <= chk_last_next;
        run_endm1_reg  <= run_endm1_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

/* src/bpfa_checker.sv */
`default_nettype none
`include "bitmap_page_frame_allocator_core_assert.svh"

// Port-level checks of the allocator.
module bpfa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [bpfa_pkg::PAGE_W-1:0]   rsp_page_index,
    input wire logic                          rsp_status
);

    // A result stays offered until it is taken.
    `BPFA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // A stalled result keeps its payload.
    `BPFA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_page_index) && $stable(rsp_status))

    // A failed allocation reports page zero.
    `BPFA_ASSERT_IMP(a_fail_zero, clk, rst_n, rsp_valid && rsp_status, rsp_page_index == '0)

    // Items are handled one at a time: ready drops after an accepted item.
    `BPFA_ASSERT_NEXT(a_one_item, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_page_index (rsp.page_index),
    .rsp_status     (rsp.status)
);

`default_nettype wire

/* tb/bitmap_page_frame_allocator_core_tb.sv */
`default_nettype none

module bitmap_page_frame_allocator_core_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int MAP_PAGES      = 65536;
    localparam int MAP_WORDS      = MAP_PAGES / bpfa_pkg::WORD_W;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_SPACING   = 600;
    localparam int HOLD_COUNT     = 2;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 50;
    localparam int TIMEOUT_CYCLES = 6000000;
    localparam int PHASE_COUNT    = 9;

    // Request code that the block does not define; it must be ignored.
    localparam logic [bpfa_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_PAGE = 1'b1;

    typedef struct packed {
        logic [bpfa_pkg::REQ_W-1:0]  req_type;
        logic [bpfa_pkg::PAGE_W-1:0] first_page;
        logic [bpfa_pkg::LIM_W-1:0]  page_count;
    } page_req_t;

    typedef struct packed {
        logic [bpfa_pkg::PAGE_W-1:0] page_index;
        logic                        status;
    } page_reply_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [bpfa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bpfa_pkg::CFG_DATA_W-1:0] cfg_data;

    bpfa_req_if req_ch ();
    bpfa_rsp_if rsp_ch ();

    bitmap_page_frame_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Mirror of the allocator state and its registers; all pages start used.
    logic [bpfa_pkg::WORD_W-1:0] page_used_words [MAP_WORDS] = '{default: '1};
    logic [bpfa_pkg::LIM_W-1:0]  alloc_hint = '0;
    logic [bpfa_pkg::LIM_W-1:0]  managed_pages;
    logic                        downward;

    page_req_t   req_backlog [$];
    page_reply_t outcomes_due [$];
    page_req_t   offered;
    page_reply_t granted;
    page_reply_t awaited;
    logic        offering;

    int unsigned items_queued;
    int unsigned items_taken;
    int unsigned replies_seen;
    int unsigned bad_count;
    int unsigned allocs_granted;
    int unsigned allocs_refused;
    int unsigned settings_used;
    int unsigned send_gap;
    int unsigned send_calm;
    int unsigned take_gap;
    int unsigned take_calm;
    int unsigned hold_left;
    int unsigned holds_done;

    // Register settings for the phases after the one that runs on reset values.
    int unsigned phase_pages [PHASE_COUNT] =
        '{1, 1, 0, 100, 257, 4096, 131071, 65536, 2000};
    bit          phase_down  [PHASE_COUNT] = '{0, 1, 0, 1, 0, 1, 1, 0, 0};
    int unsigned phase_items [PHASE_COUNT] =
        '{60, 60, 30, 250, 250, 250, 100, 150, 225};

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Page count as the block sees it: never more than the map holds.
    function automatic int unsigned usable_pages();
        return (managed_pages > MAP_PAGES) ? MAP_PAGES : int'(managed_pages);
    endfunction

    // Free pages of one map word, masked to the pages in use.
    function automatic logic [bpfa_pkg::WORD_W-1:0] free_in_word(input int unsigned w,
                                                                 input int unsigned lim);
        logic [bpfa_pkg::WORD_W-1:0] spare;
        int unsigned                 base;
        spare = ~page_used_words[w];
        base  = w * bpfa_pkg::WORD_W;
        if (base + bpfa_pkg::WORD_W > lim)
        begin
            spare &= (64'd1 << (lim - base)) - 64'd1;
        end
        return spare;
    endfunction

    function automatic bit find_lowest_free(input int unsigned lim, output int unsigned page);
        logic [bpfa_pkg::WORD_W-1:0] spare;
        page = 0;
        for (int unsigned w = 0; w * bpfa_pkg::WORD_W < lim; w++)
        begin
            spare = free_in_word(w, lim);
            if (spare != '0)
            begin
                for (int b = 0; b < bpfa_pkg::WORD_W; b++)
                begin
                    if (spare[b])
                    begin
                        page = w * bpfa_pkg::WORD_W + b;
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic bit find_highest_free(input int unsigned lim, output int unsigned page);
        logic [bpfa_pkg::WORD_W-1:0] spare;
        page = 0;
        if (lim == 0)
        begin
            return 1'b0;
        end
        for (int w = (lim - 1) / bpfa_pkg::WORD_W; w >= 0; w--)
        begin
            spare = free_in_word(w, lim);
            if (spare != '0)
            begin
                for (int b = bpfa_pkg::WORD_W - 1; b >= 0; b--)
                begin
                    if (spare[b])
                    begin
                        page = w * bpfa_pkg::WORD_W + b;
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the mirrored map and returns the reply it earns.
    function automatic page_reply_t serve_page_request(input page_req_t r);
        page_reply_t reply;
        int unsigned lim;
        int unsigned h;
        int unsigned stop;
        bit          found;
        bit          rescan;
        reply.page_index = '0;
        reply.status     = STATUS_OK;
        lim = usable_pages();
        if (r.req_type == bpfa_pkg::REQ_ALLOC)
        begin
            h      = alloc_hint;
            found  = 1'b1;
            rescan = (h >= lim);
            if (!rescan)
            begin
                rescan = page_used_words[h / bpfa_pkg::WORD_W][h % bpfa_pkg::WORD_W];
            end
            if (rescan)
            begin
                found = downward ? find_highest_free(lim, h) : find_lowest_free(lim, h);
            end
            if (found)
            begin
                page_used_words[h / bpfa_pkg::WORD_W][h % bpfa_pkg::WORD_W] = 1'b1;
                reply.page_index = h[bpfa_pkg::PAGE_W-1:0];
                alloc_hint = downward ? bpfa_pkg::LIM_W'(h - 1) : bpfa_pkg::LIM_W'(h + 1);
            end
            else
            begin
                reply.status = STATUS_NO_PAGE;
            end
        end
        else if (r.req_type == bpfa_pkg::REQ_RELEASE || r.req_type == bpfa_pkg::REQ_RESERVE)
        begin
            // The run is clipped at the pages in use.
            stop = 32'(r.first_page) + 32'(r.page_count);
            if (stop > lim)
            begin
                stop = lim;
            end
            for (int unsigned p = r.first_page; p < stop; p++)
            begin
                page_used_words[p / bpfa_pkg::WORD_W][p % bpfa_pkg::WORD_W] =
                    (r.req_type == bpfa_pkg::REQ_RESERVE);
            end
        end
        return reply;
    endfunction

    // Idle length for either side: mostly none or short, a few long, and
    // now and then a calm stretch with no idling at all.
    function automatic int unsigned idle_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_request(input logic [bpfa_pkg::REQ_W-1:0]  kind,
                                 input logic [bpfa_pkg::PAGE_W-1:0] first,
                                 input logic [bpfa_pkg::LIM_W-1:0]  count);
        page_req_t r;
        r.req_type   = kind;
        r.first_page = first;
        r.page_count = count;
        req_backlog.push_back(r);
        items_queued++;
    endtask

    // Random request aimed at a window of pages next to where allocation
    // happens, so that allocations, releases and reservations interact.
    task automatic queue_random_request();
        int unsigned lim;
        int unsigned span;
        int unsigned base;
        int unsigned roll;
        logic [bpfa_pkg::REQ_W-1:0]  kind;
        logic [bpfa_pkg::PAGE_W-1:0] first;
        logic [bpfa_pkg::LIM_W-1:0]  count;
        lim  = usable_pages();
        span = (lim == 0) ? 64 : ((lim < 512) ? lim : 512);
        base = (downward && lim > span) ? lim - span : 0;

        roll = $urandom_range(0, 99);
        if (roll < 50)
            kind = bpfa_pkg::REQ_ALLOC;
        else if (roll < 78)
            kind = bpfa_pkg::REQ_RELEASE;
        else if (roll < 97)
            kind = bpfa_pkg::REQ_RESERVE;
        else
            kind = REQ_UNUSED;

        if ($urandom_range(0, 99) < 85)
            first = bpfa_pkg::PAGE_W'(base + $urandom_range(0, span + 8));
        else
            first = bpfa_pkg::PAGE_W'($urandom);

        roll = $urandom_range(0, 99);
        if (roll < 8)
            count = '0;
        else if (roll < 78)
            count = bpfa_pkg::LIM_W'($urandom_range(1, 8));
        else if (roll < 95)
            count = bpfa_pkg::LIM_W'($urandom_range(9, 128));
        else if (roll < 99)
            count = bpfa_pkg::LIM_W'($urandom_range(129, 4096));
        else
            count = bpfa_pkg::LIM_W'($urandom_range(4097, 131071));

        queue_request(kind, first, count);
    endtask

    // Register writes only happen with nothing in flight.
    task automatic write_reg(input logic [bpfa_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [bpfa_pkg::CFG_DATA_W-1:0] wdata);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= wdata;
        if (idx == bpfa_pkg::REG_PAGES_IN_USE)
            managed_pages = wdata;
        else if (idx == bpfa_pkg::REG_TOP_DOWN)
            downward = wdata[0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (items_taken != items_queued || outcomes_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Request driver: offers the backlog in order and predicts each reply
    // at the edge where the item is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            offering = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                granted = serve_page_request(offered);
                outcomes_due.push_back(granted);
                items_taken++;
                if (offered.req_type == bpfa_pkg::REQ_ALLOC)
                begin
                    if (granted.status == STATUS_OK)
                        allocs_granted++;
                    else
                        allocs_refused++;
                end
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap != 0 && hold_left == 0)
                begin
                    send_gap--;
                end
                else if (req_backlog.size() != 0)
                begin
                    offered = req_backlog.pop_front();
                    req_ch.req_type   <= offered.req_type;
                    req_ch.first_page <= offered.first_page;
                    req_ch.page_count <= offered.page_count;
                    offering = 1'b1;
                    send_gap = idle_gap(send_calm);
                end
            end
            req_ch.valid <= offering;
        end
    end

    // Reply side readiness with random stalls; a long hold overrides it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (take_gap != 0)
        begin
            take_gap--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            take_gap = idle_gap(take_calm);
        end
    end

    // Long hold on the reply side while requests keep coming, so the block
    // backs up and stops taking requests.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (holds_done < HOLD_COUNT && items_taken >= (holds_done + 1) * HOLD_SPACING)
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Reply checker: each reply is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            replies_seen++;
            if (outcomes_due.size() == 0)
            begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("reply %0d came with no request pending: page %0d status %0b",
                             replies_seen, rsp_ch.page_index, rsp_ch.status);
            end
            else
            begin
                awaited = outcomes_due.pop_front();
                if (rsp_ch.page_index !== awaited.page_index ||
                    rsp_ch.status !== awaited.status)
                begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("reply %0d wrong: expected page %0d status %0b, got page %0d status %0b",
                                 replies_seen, awaited.page_index, awaited.status,
                                 rsp_ch.page_index, rsp_ch.status);
                end
            end
        end
    end

    // Main sequence: reset, directed requests, then random phases under
    // several register settings.
    initial
    begin
        managed_pages = bpfa_pkg::PAGES_RESET;
        downward      = 1'b0;
        items_queued  = 0;
        settings_used = 1;

        cfg_write         = 1'b0;
        cfg_index         = bpfa_pkg::REG_PAGES_IN_USE;
        cfg_data          = '0;
        rst_n             = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Everything is used after reset, so the first allocation fails.
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        // Empty run and an unknown request change nothing.
        queue_request(bpfa_pkg::REQ_RELEASE, 16'd0, 17'd0);
        queue_request(REQ_UNUSED, 16'd5, 17'd9);
        queue_request(bpfa_pkg::REQ_RELEASE, 16'd0, 17'd8);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'hffff, 17'h1ffff);
        // The hint page gets reserved, forcing a rescan.
        queue_request(bpfa_pkg::REQ_RESERVE, 16'd2, 17'd2);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        // Run past the last page is clipped.
        queue_request(bpfa_pkg::REQ_RELEASE, 16'd65530, 17'h10000);
        // Reserve the whole map in one run.
        queue_request(bpfa_pkg::REQ_RESERVE, 16'd0, 17'h10000);
        queue_request(bpfa_pkg::REQ_RELEASE, 16'hffff, 17'd1);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        // Hint now sits at the page limit and nothing is free.
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        queue_request(bpfa_pkg::REQ_RELEASE, 16'hffff, 17'h1ffff);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        queue_request(bpfa_pkg::REQ_RELEASE, 16'h8000, 17'd64);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        queue_request(bpfa_pkg::REQ_RESERVE, 16'd32770, 17'd3);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        queue_request(REQ_UNUSED, 16'hffff, 17'h1ffff);
        queue_request(bpfa_pkg::REQ_RELEASE, 16'd0, 17'd100);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);
        queue_request(bpfa_pkg::REQ_RESERVE, 16'h5555, 17'h0aaaa);
        queue_request(bpfa_pkg::REQ_ALLOC, 16'd0, 17'd0);

        repeat (250) queue_random_request();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_for_drain();
            write_reg(bpfa_pkg::REG_PAGES_IN_USE, bpfa_pkg::CFG_DATA_W'(phase_pages[ph]));
            write_reg(bpfa_pkg::REG_TOP_DOWN, {16'($urandom), phase_down[ph]});
            settings_used++;
            repeat (phase_items[ph]) queue_random_request();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests under %0d register settings: %0d pages handed out, %0d refusals.",
                 items_taken, settings_used, allocs_granted, allocs_refused);
        $display("Reply channel was held off for %0d long stretches of %0d cycles.",
                 holds_done, HOLD_CYCLES);
        if (bad_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog against a hung block.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
